[hdl/ua96_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ua96_pkg
// Shared types and constants for the unsigned serial ALU.
// ----------------------------------------------------------------------------
package ua96_pkg;

	localparam int LOW_BITS = 64;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		logic carry_overflow;
		logic divide_by_zero;
	} flags_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

[hdl/ua96_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ua96_core
// Iterative datapath: one operand bit per cycle for all four commands.
// ----------------------------------------------------------------------------
module ua96_core #(
	parameter int N = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ua96_pkg::cmd_t      cmd,
	input  logic [N-1:0]        a,
	input  logic [N-1:0]        b,
	input  logic                ack,
	output ua96_pkg::core_stat_t stat,
	output logic [N-1:0]        result,
	output logic [N-1:0]        remainder,
	output ua96_pkg::flags_t    flags
);
	import ua96_pkg::*;

	localparam int CW = $clog2(N);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	cmd_t           cmd_q;
	logic [N-1:0]   a_q, b_q, acc_q;
	logic           carry_q, ovf_q, dz_q;

	logic [N-1:0]   a_d, b_d, acc_d;
	logic           carry_d, ovf_d;

	// step logic
	logic           bit_b, bit_s;
	logic [N-1:0]   sh, rem2;
	logic [N:0]     msum, diff;
	logic           take;

	always_comb begin
		bit_b = (cmd_q == CMD_SUB) ? ~b_q[0] : b_q[0];
		bit_s = a_q[0] ^ bit_b ^ carry_q;
		sh    = {acc_q[N-2:0], 1'b0};
		msum  = {1'b0, sh} + {1'b0, a_q};
		rem2  = {acc_q[N-2:0], a_q[N-1]};
		diff  = {1'b0, rem2} - {1'b0, b_q};
		take  = acc_q[N-1] | ~diff[N];

		a_d     = a_q;
		b_d     = b_q;
		acc_d   = acc_q;
		carry_d = carry_q;
		ovf_d   = ovf_q;
		case (cmd_q)
			CMD_ADD, CMD_SUB: begin
				// LSB first; the sum bit enters at the top of a_q
				a_d     = {bit_s, a_q[N-1:1]};
				b_d     = {1'b0, b_q[N-1:1]};
				carry_d = (a_q[0] & bit_b) | (a_q[0] & carry_q) | (bit_b & carry_q);
			end
			CMD_MUL: begin
				// MSB of b first, shift-add into acc
				b_d   = {b_q[N-2:0], 1'b0};
				acc_d = b_q[N-1] ? msum[N-1:0] : sh;
				ovf_d = ovf_q | acc_q[N-1] | (b_q[N-1] & msum[N]);
			end
			CMD_DIV: begin
				// restoring division; quotient bits fill a_q from the bottom
				acc_d = take ? diff[N-1:0] : rem2;
				a_d   = {a_q[N-2:0], take};
			end
			default: begin
				a_d = a_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= CW'(N - 1);
						if (cmd == CMD_DIV && b == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - CW'(1);
				end
				ST_DONE: begin
					if (ack)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q   <= cmd;
			a_q     <= a;
			b_q     <= b;
			acc_q   <= '0;
			carry_q <= (cmd == CMD_SUB);
			ovf_q   <= 1'b0;
			dz_q    <= (cmd == CMD_DIV) && (b == '0);
		end else if (state_q == ST_RUN) begin
			a_q     <= a_d;
			b_q     <= b_d;
			acc_q   <= acc_d;
			carry_q <= carry_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		stat.idle = (state_q == ST_IDLE);
		stat.done = (state_q == ST_DONE);
		result    = '0;
		remainder = '0;
		flags     = '0;
		case (cmd_q)
			CMD_ADD: begin
				result               = a_q;
				flags.carry_overflow = carry_q;
			end
			CMD_SUB: begin
				result = a_q;
			end
			CMD_MUL: begin
				result               = ovf_q ? '0 : acc_q;
				flags.carry_overflow = ovf_q;
			end
			CMD_DIV: begin
				if (dz_q) begin
					flags.divide_by_zero = 1'b1;
				end else begin
					result    = a_q;
					remainder = acc_q;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

[hdl/ua96_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ua96_obuf
// Output word register; holds a finished word until the receiver takes it.
// ----------------------------------------------------------------------------
module ua96_obuf #(
	parameter int N = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_req,
	input  logic [N-1:0]     result_in,
	input  logic [N-1:0]     remainder_in,
	input  ua96_pkg::flags_t flags_in,
	output logic             load_ack,
	output logic             valid,
	input  logic             stall,
	output logic [N-1:0]     result,
	output logic [N-1:0]     remainder,
	output ua96_pkg::flags_t flags
);
	import ua96_pkg::*;

	logic       valid_q;
	logic [N-1:0] result_q, remainder_q;
	flags_t     flags_q;

	assign load_ack = load_req && (!valid_q || !stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_ack)
			valid_q <= 1'b1;
		else if (!stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_ack) begin
			result_q    <= result_in;
			remainder_q <= remainder_in;
			flags_q     <= flags_in;
		end
	end

	assign valid     = valid_q;
	assign result    = result_q;
	assign remainder = remainder_q;
	assign flags     = flags_q;

endmodule

[hdl/unsigned_96bit_alu_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_96bit_alu_top
// Unsigned add / subtract / multiply / divide on OPERAND_BITS-bit operands.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with command and the two operands, each
// as a 64-bit low part and an (OPERAND_BITS-64)-bit high part. Output channel:
// out_valid / out_stall with result, remainder and two flags. A word moves at
// a clock edge where valid is high and stall is low.
// Every command runs through the same serial sequencer, one operand bit per
// cycle: add and subtract ripple one carry bit a cycle, multiply and divide
// take one bit of b (or a) per step against a full-width adder. A word goes
// from acceptance through the run loop to the done state and then into the
// output register; divide by zero skips the loop. One word is in work at a
// time: in_stall stays high until the finished word has left the core.
// A finished word sits in the output register while the next one is taken
// and computed; if the receiver still stalls when that one is done, the core
// holds it and in_stall stays high until the output register drains.
// Reset clears the sequencer and the output valid; no word is pending after.
// ----------------------------------------------------------------------------
module unsigned_96bit_alu_top #(
	parameter int OPERAND_BITS = 96
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic [63:0]              a_low,
	input  logic [OPERAND_BITS-65:0] a_high,
	input  logic [63:0]              b_low,
	input  logic [OPERAND_BITS-65:0] b_high,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [63:0]              result_low,
	output logic [OPERAND_BITS-65:0] result_high,
	output logic [63:0]              remainder_low,
	output logic [OPERAND_BITS-65:0] remainder_high,
	output logic                     carry_overflow,
	output logic                     divide_by_zero
);
	import ua96_pkg::*;

	localparam int N = OPERAND_BITS;

	core_stat_t   stat;
	logic         start, ack;
	logic [N-1:0] core_result, core_rem, buf_result, buf_rem;
	flags_t       core_flags, buf_flags;

	assign in_stall = !stat.idle;
	assign start    = in_valid && stat.idle;

	ua96_core #(.N(N)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd_t'(command)),
		.a         ({a_high, a_low}),
		.b         ({b_high, b_low}),
		.ack       (ack),
		.stat      (stat),
		.result    (core_result),
		.remainder (core_rem),
		.flags     (core_flags)
	);

	ua96_obuf #(.N(N)) u_obuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_req     (stat.done),
		.result_in    (core_result),
		.remainder_in (core_rem),
		.flags_in     (core_flags),
		.load_ack     (ack),
		.valid        (out_valid),
		.stall        (out_stall),
		.result       (buf_result),
		.remainder    (buf_rem),
		.flags        (buf_flags)
	);

	assign result_low     = buf_result[LOW_BITS-1:0];
	assign result_high    = buf_result[N-1:LOW_BITS];
	assign remainder_low  = buf_rem[LOW_BITS-1:0];
	assign remainder_high = buf_rem[N-1:LOW_BITS];
	assign carry_overflow = buf_flags.carry_overflow;
	assign divide_by_zero = buf_flags.divide_by_zero;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 96-bit unsigned add / sub / mul / div unit.
// ----------------------------------------------------------------------------
// A queue of pending words is filled up front. It holds a directed set of
// corner cases first and then random commands with shaped operands. A
// clocked driver sends the words over the valid/stall input channel with
// random gaps. Each accepted word gets its expected outcome computed from
// plain wide arithmetic. A clocked monitor applies random stall on the
// output channel and checks every returned word, field by field, against
// the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module testbench;
	import ua96_pkg::*;

	localparam int OPERAND_BITS = 96;
	localparam int HIGH_BITS    = OPERAND_BITS - LOW_BITS;
	localparam int LATENCY      = OPERAND_BITS + 2;
	localparam int RANDOM_WORDS = 726;
	localparam int DRAIN_EVERY  = 150;
	localparam int CALM_FIRST   = 300;
	localparam int CALM_LAST    = 400;
	localparam int PRINT_CAP    = 100;

	typedef logic [OPERAND_BITS-1:0] operand_t;

	localparam operand_t ALL_ONES = '1;
	localparam operand_t ONE      = 1;
	localparam operand_t TOP_BIT  = ONE << (OPERAND_BITS - 1);

	typedef struct {
		cmd_t     cmd;
		operand_t a;
		operand_t b;
		bit       drain;
	} alu_word_t;

	typedef struct {
		int unsigned seq;
		cmd_t        cmd;
		operand_t    value;
		operand_t    rem;
		logic        carry;
		logic        dz;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = CMD_ADD;
	logic [63:0]          a_low = '0;
	logic [HIGH_BITS-1:0] a_high = '0;
	logic [63:0]          b_low = '0;
	logic [HIGH_BITS-1:0] b_high = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [63:0]          result_low;
	logic [HIGH_BITS-1:0] result_high;
	logic [63:0]          remainder_low;
	logic [HIGH_BITS-1:0] remainder_high;
	logic                 carry_overflow;
	logic                 divide_by_zero;

	alu_word_t   pending_words[$];
	alu_result_t expected_results[$];
	alu_word_t   sent_word;
	alu_result_t want;

	int unsigned total_words = 0;
	int unsigned sent_count = 0;
	int unsigned recv_count = 0;
	int unsigned error_count = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	bit          take_next;

	unsigned_96bit_alu_top #(
		.OPERAND_BITS(OPERAND_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.a_low         (a_low),
		.a_high        (a_high),
		.b_low         (b_low),
		.b_high        (b_high),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_low    (result_low),
		.result_high   (result_high),
		.remainder_low (remainder_low),
		.remainder_high(remainder_high),
		.carry_overflow(carry_overflow),
		.divide_by_zero(divide_by_zero)
	);

	always #4 clk = ~clk;

	function automatic alu_result_t predict_alu(int unsigned seq, alu_word_t w);
		alu_result_t r;
		logic [OPERAND_BITS:0]     sum;
		logic [2*OPERAND_BITS-1:0] prod;
		r.seq   = seq;
		r.cmd   = w.cmd;
		r.value = '0;
		r.rem   = '0;
		r.carry = 1'b0;
		r.dz    = 1'b0;
		case (w.cmd)
			CMD_ADD: begin
				sum = {1'b0, w.a} + {1'b0, w.b};
				r.value = sum[OPERAND_BITS-1:0];
				r.carry = sum[OPERAND_BITS];
			end
			CMD_SUB: begin
				r.value = w.a - w.b;
			end
			CMD_MUL: begin
				prod = {{OPERAND_BITS{1'b0}}, w.a} * {{OPERAND_BITS{1'b0}}, w.b};
				// a product that does not fit reads back as zero with the flag
				if (prod[2*OPERAND_BITS-1:OPERAND_BITS] != '0)
					r.carry = 1'b1;
				else
					r.value = prod[OPERAND_BITS-1:0];
			end
			default: begin
				if (w.b == '0) begin
					r.dz = 1'b1;
				end else begin
					r.value = w.a / w.b;
					r.rem   = w.a % w.b;
				end
			end
		endcase
		return r;
	endfunction

	function automatic operand_t len_mask(int unsigned len);
		if (len >= OPERAND_BITS)
			return ALL_ONES;
		return (ONE << len) - ONE;
	endfunction

	function automatic operand_t pick_operand(int unsigned max_len);
		operand_t v;
		v = {$urandom(), $urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 2))
					0: v = '0;
					1: v = ONE;
					default: v = ALL_ONES;
				endcase
			end
			1: v = (max_len == 0) ? '0 : ONE << $urandom_range(0, max_len - 1);
			2: v = len_mask(max_len) - operand_t'($urandom_range(0, 15));
			3, 4: v = v & len_mask($urandom_range(0, max_len));
			default: ;
		endcase
		return v & len_mask(max_len);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	task automatic queue_word(cmd_t cmd, operand_t a, operand_t b, bit drain);
		alu_word_t w;
		w.cmd   = cmd;
		w.a     = a;
		w.b     = b;
		w.drain = drain;
		pending_words.push_back(w);
	endtask

	task automatic build_directed();
		queue_word(CMD_ADD, ALL_ONES, ALL_ONES, 1'b0);
		queue_word(CMD_ADD, '0, '0, 1'b0);
		queue_word(CMD_ADD, len_mask(LOW_BITS), ONE, 1'b0);
		queue_word(CMD_ADD, ALL_ONES, ONE, 1'b0);
		queue_word(CMD_SUB, '0, ONE, 1'b0);
		queue_word(CMD_SUB, operand_t'(5), operand_t'(5), 1'b0);
		queue_word(CMD_SUB, ALL_ONES, '0, 1'b0);
		queue_word(CMD_SUB, ONE << LOW_BITS, ONE, 1'b0);
		queue_word(CMD_MUL, ALL_ONES, ALL_ONES, 1'b0);
		// exactly 2^96: smallest overflowing product
		queue_word(CMD_MUL, ONE << 48, ONE << 48, 1'b0);
		queue_word(CMD_MUL, TOP_BIT, ONE, 1'b1);
		queue_word(CMD_MUL, TOP_BIT, operand_t'(2), 1'b0);
		queue_word(CMD_MUL, ALL_ONES, ONE, 1'b0);
		queue_word(CMD_MUL, '0, ALL_ONES, 1'b0);
		queue_word(CMD_MUL, (ONE << 48) - ONE, (ONE << 48) + ONE, 1'b0);
		queue_word(CMD_DIV, ALL_ONES, '0, 1'b0);
		queue_word(CMD_DIV, '0, '0, 1'b0);
		queue_word(CMD_DIV, ALL_ONES, ONE, 1'b0);
		queue_word(CMD_DIV, ALL_ONES, ALL_ONES, 1'b0);
		queue_word(CMD_DIV, operand_t'(7), ALL_ONES, 1'b0);
		// divisor above 2^95: partial remainder spills past the top bit
		queue_word(CMD_DIV, ALL_ONES, TOP_BIT + ONE, 1'b0);
		queue_word(CMD_DIV, ALL_ONES, operand_t'(3), 1'b0);
		queue_word(CMD_DIV, ALL_ONES - operand_t'(9), ONE << LOW_BITS, 1'b0);
		queue_word(CMD_DIV, '0, operand_t'(5), 1'b0);
	endtask

	task automatic build_random();
		cmd_t        cmd;
		int unsigned la;
		operand_t    a;
		operand_t    b;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			cmd = cmd_t'($urandom_range(0, 3));
			if (cmd == CMD_MUL && $urandom_range(0, 1) == 1) begin
				// keep the combined bit length in range so products often fit
				la = $urandom_range(0, OPERAND_BITS);
				a  = pick_operand(la);
				b  = pick_operand(OPERAND_BITS - la);
			end else if (cmd == CMD_DIV) begin
				a = pick_operand(OPERAND_BITS);
				b = pick_operand($urandom_range(0, OPERAND_BITS));
			end else begin
				a = pick_operand(OPERAND_BITS);
				b = pick_operand(OPERAND_BITS);
			end
			queue_word(cmd, a, b, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
		end
	endtask

	task automatic report_mismatch(string msg);
		if (error_count < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("word %0d %s: %s got %h want %h",
				want.seq, want.cmd.name(), name, got, exp_val));
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command  <= CMD_ADD;
			a_low    <= '0;
			a_high   <= '0;
			b_low    <= '0;
			b_high   <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_alu(sent_count, sent_word));
				sent_count++;
				gap_left = (sent_count >= CALM_FIRST && sent_count < CALM_LAST) ? 0 : pick_gap();
			end
			if (!in_valid || !in_stall) begin
				take_next = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (pending_words.size() > 0 &&
						(!pending_words[0].drain || sent_count == recv_count))
					take_next = 1'b1;
				if (take_next) begin
					sent_word = pending_words.pop_front();
					command <= sent_word.cmd;
					a_low   <= sent_word.a[LOW_BITS-1:0];
					a_high  <= sent_word.a[OPERAND_BITS-1:LOW_BITS];
					b_low   <= sent_word.b[LOW_BITS-1:0];
					b_high  <= sent_word.b[OPERAND_BITS-1:LOW_BITS];
				end
				in_valid <= take_next;
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			recv_count <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("result_low", result_low, want.value[LOW_BITS-1:0]);
					check_field("result_high", 64'(result_high),
						64'(want.value[OPERAND_BITS-1:LOW_BITS]));
					check_field("remainder_low", remainder_low, want.rem[LOW_BITS-1:0]);
					check_field("remainder_high", 64'(remainder_high),
						64'(want.rem[OPERAND_BITS-1:LOW_BITS]));
					check_field("carry_overflow", 64'(carry_overflow), 64'(want.carry));
					check_field("divide_by_zero", 64'(divide_by_zero), 64'(want.dz));
				end
				recv_count <= recv_count + 1;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = (recv_count >= CALM_FIRST && recv_count < CALM_LAST + 20) ?
					0 : pick_gap();
			end
		end
	end

	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		build_directed();
		build_random();
		total_words = pending_words.size();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (sent_count < total_words)
			@(negedge clk);
		while (recv_count < sent_count)
			@(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d result words never came",
				expected_results.size()));
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hdl/ua96_pkg.sv
hdl/ua96_core.sv
hdl/ua96_obuf.sv
hdl/unsigned_96bit_alu_top.sv
tb/testbench.sv
